### rtl/scbpm_pkg.sv
// scbpm_pkg: shared constants and types for the size-class block pool manager
// no dependencies
`default_nettype none
package scbpm_pkg;
    localparam int NUM_BLOCKS_DEF       = 256;
    localparam int NUM_CLASSES_DEF      = 4;
    localparam int BLOCKS_PER_CLASS_DEF = 64;
    localparam int HW = 9;   // handle field width
    localparam int CW = 16;  // capacity width

    typedef enum logic [2:0] {
        ACT_ALLOC = 3'd0,
        ACT_FREE  = 3'd1,
        ACT_LINK  = 3'd2,
        ACT_ITER  = 3'd3,
        ACT_CHECK = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_RO   = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;
    localparam logic [1:0] ST_LEN  = 2'd3;

    localparam logic [2:0] REG_CAP0 = 3'd0;
    localparam logic [2:0] REG_CAP1 = 3'd1;
    localparam logic [2:0] REG_CAP2 = 3'd2;
    localparam logic [2:0] REG_CAP3 = 3'd3;
    localparam logic [2:0] REG_RO   = 3'd4;

    // configuration snapshot handed to the engine
    typedef struct packed {
        logic [CW-1:0] cap0;
        logic [CW-1:0] cap1;
        logic [CW-1:0] cap2;
        logic [CW-1:0] cap3;
        logic          ro;
    } t_cfg;
endpackage
`default_nettype wire

### rtl/scbpm_regs.sv
// scbpm_regs: APB configuration registers
// depends on scbpm_pkg
`default_nettype none
module scbpm_regs
    import scbpm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);
    t_cfg r_cfg;
    logic [2:0] w_idx;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cap0 <= 16'd64;
            r_cfg.cap1 <= 16'd256;
            r_cfg.cap2 <= 16'd1024;
            r_cfg.cap3 <= 16'd4096;
            r_cfg.ro   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_CAP0: r_cfg.cap0 <= pwdata[15:0];
                REG_CAP1: r_cfg.cap1 <= pwdata[15:0];
                REG_CAP2: r_cfg.cap2 <= pwdata[15:0];
                REG_CAP3: r_cfg.cap3 <= pwdata[15:0];
                REG_RO:   r_cfg.ro   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_CAP0: prdata = {16'd0, r_cfg.cap0};
            REG_CAP1: prdata = {16'd0, r_cfg.cap1};
            REG_CAP2: prdata = {16'd0, r_cfg.cap2};
            REG_CAP3: prdata = {16'd0, r_cfg.cap3};
            REG_RO:   prdata = {31'd0, r_cfg.ro};
            default:  prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

### rtl/scbpm_link_mem.sv
// scbpm_link_mem: link word store, one write and one registered read port
// depends on scbpm_pkg
`default_nettype none
module scbpm_link_mem
    import scbpm_pkg::*;
#(
    parameter int DEPTH = NUM_BLOCKS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [HW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [HW-1:0]      o_rdata
);
    logic [HW-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/scbpm_engine.sv
// scbpm_engine: action sequencer doing read-modify-write on the link store
// depends on scbpm_pkg, scbpm_link_mem
`default_nettype none
module scbpm_engine
    import scbpm_pkg::*;
#(
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
    parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
    parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_action,
    input  wire logic [15:0]   i_request_size,
    input  wire logic [HW-1:0] i_target_handle,
    input  wire logic [HW-1:0] i_second_handle,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [HW-1:0]      o_result_handle,
    output logic [1:0]         o_status,
    output logic [CW-1:0]      o_capacity
);
    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int NW  = AW + 1; // walk counter holds NUM_BLOCKS

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH,
        S_AL_RD, S_AL_F, S_AL_FN, S_AL_NEXT,
        S_FR_RD, S_FR_LAST, S_FR_FST, S_FR_POS, S_FR_NXT, S_FR_PUSH, S_FR_TGT,
        S_LK_RD, S_LK_SL, S_LK_SLN, S_LK_MF, S_LK_W1, S_LK_W2, S_LK_W3, S_LK_W4,
        S_IT_RD, S_IT_2,
        S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]    r_act;
    logic [15:0]   r_size;
    logic [HW-1:0] r_tgt, r_sec;
    logic [HW-1:0] r_tail [NUM_CLASSES];
    logic [HW-1:0] r_a, r_b, r_c, r_d;   // scratch handles
    logic [CLW-1:0] r_cls;
    logic [NW-1:0]  r_n;
    logic [HW-1:0]  r_res;
    logic [1:0]     r_st;
    logic [CW-1:0]  r_cap;
    logic           r_ovalid;
    // output stage, held while the receiver stalls
    logic [HW-1:0]  r_ores;
    logic [1:0]     r_ost;
    logic [CW-1:0]  r_ocap;
    // push helper state: handle to push, next state after push, push phase
    logic [HW-1:0]  r_ph;
    logic [1:0]     r_pstep;
    t_state         r_pret;

    // memory port
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [HW-1:0] w_wdata, w_rdata;

    scbpm_link_mem #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [HW-1:0] h);
        logic [HW-1:0] m;
        m = h - HW'(1);
        return m[AW-1:0];
    endfunction

    // class by comparing against the class boundaries
    function automatic logic [CLW-1:0] class_of(input logic [HW-1:0] h);
        logic [HW-1:0] m;
        int q;
        m = h - HW'(1);
        q = 0;
        for (int k = 1; k < NUM_CLASSES; k++)
            if (int'(m) >= k * BLOCKS_PER_CLASS) q = k;
        return CLW'(q);
    endfunction

    function automatic logic [CW-1:0] cap_of(input t_cfg c, input logic [CLW-1:0] k);
        logic [1:0] k2;
        k2 = 2'(k);
        case (k2)
            2'd0: return c.cap0;
            2'd1: return c.cap1;
            2'd2: return c.cap2;
            default: return c.cap3;
        endcase
    endfunction

    function automatic logic hvalid(input logic [HW-1:0] h);
        return (h != '0) && ({1'b0, h} <= (HW+1)'(NUM_BLOCKS));
    endfunction

    // primary class for allocate
    logic [CLW-1:0] w_primary;
    always_comb begin
        w_primary = CLW'(NUM_CLASSES - 1);
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
            if (r_size <= cap_of(i_cfg, CLW'(k))) w_primary = CLW'(k);
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_result_handle = r_ores;
    assign o_status = r_ost;
    assign o_capacity = r_ocap;

    logic [HW-1:0] w_pt;
    assign w_pt = r_tail[class_of(r_ph)];

    // link of the second block's last member as seen after the target is rewritten
    logic [HW-1:0] w_sln;
    assign w_sln = (r_b == r_tgt) ? r_b : r_c;

    // result posting and final result handle
    logic          w_post;
    logic [HW-1:0] w_fin_res;
    assign w_post = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    always_comb begin
        w_fin_res = r_res;
        if (r_act == 3'(ACT_ITER) && hvalid(r_tgt)) begin
            if (r_a == r_sec) w_fin_res = '0;
            else if (r_sec == '0 || hvalid(r_sec)) w_fin_res = w_rdata;
            else w_fin_res = '0;
        end
    end

    // memory port control, driven from state
    always_comb begin
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1; w_waddr = r_n[AW-1:0];
                if (class_of(r_a) != class_of(r_a + HW'(1)) ||
                    {1'b0, r_a} == (HW+1)'(NUM_BLOCKS))
                    w_wdata = r_b;
                else
                    w_wdata = r_a + HW'(1);
            end
            S_AL_RD:  w_raddr = addr_of(r_tail[r_cls]);
            S_AL_F: begin
                if (w_rdata == '0 || w_rdata == r_tail[r_cls]) begin
                    w_we = 1'b1; w_waddr = addr_of(r_tail[r_cls]);
                end else w_raddr = addr_of(w_rdata);
            end
            S_AL_FN: begin
                w_we = 1'b1; w_waddr = addr_of(r_tail[r_cls]); w_wdata = w_rdata;
            end
            S_AL_NEXT: begin
                w_we = (r_res != '0); w_waddr = addr_of(r_res);
            end
            S_FR_RD, S_IT_RD, S_LK_RD: w_raddr = addr_of(r_tgt);
            S_FR_LAST: w_raddr = addr_of(w_rdata);
            S_FR_POS:  w_raddr = addr_of(r_d);
            S_FR_PUSH: begin
                if (r_pstep == 2'd0) begin
                    if (w_pt == '0) begin
                        w_we = 1'b1; w_waddr = addr_of(r_ph); w_wdata = r_ph;
                    end else w_raddr = addr_of(w_pt);
                end else if (r_pstep == 2'd1) begin
                    w_we = 1'b1; w_waddr = addr_of(r_ph); w_wdata = w_rdata;
                end else begin
                    w_we = 1'b1; w_waddr = addr_of(w_pt); w_wdata = r_ph;
                end
            end
            S_LK_SL: w_raddr = addr_of(r_sec);
            S_LK_SLN: w_raddr = addr_of(w_rdata);
            S_LK_MF: if (r_a != '0) w_raddr = addr_of(r_a);
            S_LK_W1: begin w_we = 1'b1; w_waddr = addr_of(r_tgt);
                w_wdata = (r_b == '0) ? r_sec : r_b; end
            S_LK_W2: begin w_we = 1'b1; w_waddr = addr_of(r_sec);
                w_wdata = (r_b == '0) ? ((r_a == '0) ? r_sec : r_d) : w_sln; end
            S_LK_W3: begin
                if (r_b != '0) begin
                    w_we = 1'b1; w_waddr = addr_of(r_b);
                    w_wdata = (r_a == '0) ? r_sec : r_d;
                end else if (r_a != '0) begin
                    w_we = 1'b1; w_waddr = addr_of(r_a); w_wdata = r_sec;
                end
            end
            S_LK_W4: begin
                if (r_b != '0 && r_a != '0) begin
                    w_we = 1'b1; w_waddr = addr_of(r_a); w_wdata = r_sec;
                end
            end
            S_IT_2: w_raddr = (r_sec == '0) ? addr_of(w_rdata) : addr_of(r_sec);
            // keep the iterate read alive while the result waits
            S_OUT: w_raddr = (r_sec == '0) ? addr_of(r_a) : addr_of(r_sec);
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
            r_ores   <= '0;
            r_ost    <= ST_OK;
            r_ocap   <= '0;
            r_n      <= '0;
            r_a      <= HW'(1);
            r_b      <= HW'(1);
            r_pstep  <= 2'd0;
            for (int k = 0; k < NUM_CLASSES; k++) r_tail[k] <= '0;
        end else begin
            // output stage
            if (w_post) begin
                r_ovalid <= 1'b1;
                r_ores   <= w_fin_res;
                r_ost    <= r_st;
                r_ocap   <= r_cap;
            end else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                // build the free rings, one entry a cycle
                S_INIT: begin
                    r_tail[class_of(r_a)] <= r_a;
                    if (class_of(r_a) != class_of(r_a + HW'(1)))
                        r_b <= r_a + HW'(1);
                    r_a <= r_a + HW'(1);
                    r_n <= r_n + NW'(1);
                    if (r_n == NW'(NUM_BLOCKS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_act <= i_action; r_size <= i_request_size;
                    r_tgt <= i_target_handle; r_sec <= i_second_handle;
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_res <= '0; r_st <= ST_OK; r_cap <= '0;
                    r_cls <= w_primary;
                    if (r_act > 3'(ACT_CHECK)) r_state <= S_OUT;
                    else if (i_cfg.ro && r_act != 3'(ACT_ITER)) begin
                        r_st <= ST_RO; r_state <= S_OUT;
                    end else if (r_act == 3'(ACT_ALLOC)) r_state <= S_AL_RD;
                    else if (!hvalid(r_tgt)) r_state <= S_OUT;
                    else begin
                        r_cap <= cap_of(i_cfg, class_of(r_tgt));
                        unique case (r_act)
                            3'(ACT_FREE): r_state <= S_FR_RD;
                            3'(ACT_LINK): r_state <= hvalid(r_sec) ? S_LK_RD : S_OUT;
                            3'(ACT_ITER): r_state <= S_IT_RD;
                            default: begin
                                if (r_size > cap_of(i_cfg, class_of(r_tgt)))
                                    r_st <= ST_LEN;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // allocate: read tail link
                S_AL_RD: begin
                    if (r_tail[r_cls] == '0) r_state <= S_AL_NEXT;
                    else r_state <= S_AL_F;
                end
                S_AL_F: begin
                    if (w_rdata == '0 || w_rdata == r_tail[r_cls]) begin
                        r_res <= r_tail[r_cls];
                        r_cap <= cap_of(i_cfg, class_of(r_tail[r_cls]));
                        r_tail[r_cls] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_res <= w_rdata;
                        r_cap <= cap_of(i_cfg, class_of(w_rdata));
                        r_state <= S_AL_FN;
                    end
                end
                S_AL_FN: r_state <= S_AL_NEXT;
                S_AL_NEXT: begin
                    if (r_res != '0) r_state <= S_OUT;
                    else if (r_cls == CLW'(NUM_CLASSES - 1)) begin
                        r_st <= ST_OUT; r_state <= S_OUT;
                    end else begin
                        r_cls <= r_cls + CLW'(1); r_state <= S_AL_RD;
                    end
                end
                // free chain walk
                S_FR_RD: r_state <= S_FR_LAST;
                S_FR_LAST: begin
                    r_a <= w_rdata; r_n <= '0;
                    if (w_rdata == '0) begin
                        r_ph <= r_tgt; r_pret <= S_OUT; r_state <= S_FR_PUSH;
                    end else r_state <= S_FR_FST;
                end
                // first member of the chain
                S_FR_FST: begin
                    r_d <= w_rdata; r_state <= S_FR_POS;
                end
                // r_d holds the member to visit
                S_FR_POS: begin
                    if (r_d == r_a || r_d == '0 || r_n == NW'(NUM_BLOCKS)) begin
                        r_ph <= r_a; r_pret <= S_FR_TGT; r_state <= S_FR_PUSH;
                    end else begin
                        r_ph <= r_d; r_state <= S_FR_NXT;
                    end
                end
                // save the next link before the push overwrites it
                S_FR_NXT: begin
                    r_d <= w_rdata; r_n <= r_n + NW'(1);
                    r_pret <= S_FR_POS; r_state <= S_FR_PUSH;
                end
                S_FR_TGT: begin
                    r_ph <= r_tgt; r_pret <= S_OUT; r_state <= S_FR_PUSH;
                end
                // push onto the tail of the block's free ring
                S_FR_PUSH: begin
                    if (r_pstep == 2'd0 && w_pt != '0) r_pstep <= 2'd1;
                    else if (r_pstep == 2'd1) r_pstep <= 2'd2;
                    else begin
                        r_pstep <= 2'd0;
                        r_tail[class_of(r_ph)] <= r_ph;
                        r_state <= r_pret;
                    end
                end
                // link
                S_LK_RD: r_state <= S_LK_SL;
                S_LK_SL: begin r_a <= w_rdata; r_state <= S_LK_SLN; end
                S_LK_SLN: begin
                    r_b <= w_rdata; r_state <= S_LK_MF;
                end
                S_LK_MF: begin
                    r_c <= w_rdata; r_state <= S_LK_W1;
                end
                S_LK_W1: begin r_d <= w_rdata; r_state <= S_LK_W2; end
                S_LK_W2: r_state <= S_LK_W3;
                S_LK_W3: r_state <= S_LK_W4;
                S_LK_W4: r_state <= S_OUT;
                // iterate
                S_IT_RD: r_state <= S_IT_2;
                S_IT_2: begin
                    r_a <= w_rdata;
                    r_state <= S_OUT;
                end
                S_OUT: if (w_post) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/size_class_block_pool_manager.sv
// size_class_block_pool_manager: top level of the segregated free list manager
// depends on scbpm_pkg, scbpm_regs, scbpm_engine
//
// Blocks 1..NUM_BLOCKS sit in per-class circular free lists held in one link
// memory with a registered read; every action is a short sequence of reads
// and writes on that memory, one access a cycle. The time from acceptance to
// the result is set by the single memory port: allocate moves on to further
// classes while the ones before are empty, and freeing a chain visits every
// chain member. The engine returns to idle after each result before the next
// item is taken, and a result stalled at the output holds the next one back.
// After reset the link memory is built in a pass over all blocks during which
// no item is accepted; configuration writes are taken at any time.
`default_nettype none
module size_class_block_pool_manager
    import scbpm_pkg::*;
#(
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
    parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
    parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_action,
    input  wire logic [15:0]   i_request_size,
    input  wire logic [HW-1:0] i_target_handle,
    input  wire logic [HW-1:0] i_second_handle,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [HW-1:0]      o_result_handle,
    output logic [1:0]         o_status,
    output logic [CW-1:0]      o_capacity
);
    t_cfg w_cfg;

    scbpm_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg)
    );

    scbpm_engine #(
        .NUM_BLOCKS(NUM_BLOCKS), .NUM_CLASSES(NUM_CLASSES),
        .BLOCKS_PER_CLASS(BLOCKS_PER_CLASS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg),
        .i_valid(i_valid), .o_stall(o_stall), .i_action(i_action),
        .i_request_size(i_request_size), .i_target_handle(i_target_handle),
        .i_second_handle(i_second_handle), .o_valid(o_valid), .i_stall(i_stall),
        .o_result_handle(o_result_handle), .o_status(o_status),
        .o_capacity(o_capacity)
    );
endmodule
`default_nettype wire

### tb/scbpm_pool_checker.sv
// scbpm_pool_checker: watches the configuration port and both item channels,
// predicts every result of the block pool manager and compares it field by field
// depends on scbpm_pkg
`timescale 1ns / 1ps
module scbpm_pool_checker
    import scbpm_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic          pready,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    input  wire logic          i_valid,
    input  wire logic          i_in_stall,
    input  wire logic [2:0]    i_action,
    input  wire logic [15:0]   i_request_size,
    input  wire logic [HW-1:0] i_target_handle,
    input  wire logic [HW-1:0] i_second_handle,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire logic [HW-1:0] i_result_handle,
    input  wire logic [1:0]    i_status,
    input  wire logic [CW-1:0] i_capacity,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int NB = NUM_BLOCKS_DEF;
    localparam int NC = NUM_CLASSES_DEF;
    localparam int BPC = BLOCKS_PER_CLASS_DEF;

    typedef struct packed {
        logic [HW-1:0] handle;
        logic [1:0]    status;
        logic [CW-1:0] cap;
    } pool_result_t;

    // shadow pool state and configuration
    logic [HW-1:0] pool_link [1:NB];
    logic [HW-1:0] class_tail [NC];
    logic [CW-1:0] class_cap [NC];
    logic          read_only_mode;
    pool_result_t  pending_results [$];

    function automatic int class_of_handle(int h);
        int c;
        c = (h - 1) / BPC;
        if (c >= NC) c = NC - 1;
        return c;
    endfunction

    function automatic bit handle_ok(int h);
        return h >= 1 && h <= NB;
    endfunction

    function automatic void reset_pool();
        int c;
        for (int h = 1; h <= NB; h++) begin
            c = class_of_handle(h);
            pool_link[h] = (h % BPC == 0 || h == NB) ? HW'(h - ((h - 1) % BPC)) : HW'(h + 1);
        end
        // last class absorbs any remainder
        for (int k = 0; k < NC; k++) class_tail[k] = '0;
        for (int h = 1; h <= NB; h++) class_tail[class_of_handle(h)] = HW'(h);
        for (int k = 0; k < NC; k++)
            if (class_tail[k] != 0) pool_link[class_tail[k]] = HW'(k * BPC + 1);
        for (int h = 1; h < NB; h++)
            if (class_of_handle(h) == class_of_handle(h + 1)) pool_link[h] = HW'(h + 1);
        class_cap[0] = 16'd64;
        class_cap[1] = 16'd256;
        class_cap[2] = 16'd1024;
        class_cap[3] = 16'd4096;
        read_only_mode = 1'b0;
    endfunction

    function automatic void push_block(int h);
        int c;
        int t;
        c = class_of_handle(h);
        t = class_tail[c];
        if (t == 0) begin
            pool_link[h] = HW'(h);
        end else begin
            pool_link[h] = pool_link[t];
            pool_link[t] = HW'(h);
        end
        class_tail[c] = HW'(h);
    endfunction

    function automatic int pop_block(int c);
        int t;
        int f;
        t = class_tail[c];
        if (t == 0) return 0;
        f = pool_link[t];
        if (f == 0 || f == t) begin
            class_tail[c] = '0;
            pool_link[t] = '0;
            return t;
        end
        pool_link[t] = pool_link[f];
        pool_link[f] = '0;
        return f;
    endfunction

    // one accepted transaction in, one predicted result out
    function automatic pool_result_t apply_action(logic [2:0] act, int size, int tgt, int sec);
        pool_result_t r;
        int primary;
        int last;
        int pos;
        int nxt;
        int n;
        int ml;
        int sl;
        int mf;
        r = '0;
        if (act > ACT_CHECK) begin
            // unused code: nothing
        end else if (read_only_mode && act != ACT_ITER) begin
            r.status = ST_RO;
        end else if (act == ACT_ALLOC) begin
            primary = NC - 1;
            for (int c = 0; c < NC; c++)
                if (size <= class_cap[c]) begin
                    primary = c;
                    break;
                end
            for (int c = primary; c < NC && r.handle == 0; c++) r.handle = HW'(pop_block(c));
            if (r.handle == 0) r.status = ST_OUT;
            else r.cap = class_cap[class_of_handle(r.handle)];
        end else if (!handle_ok(tgt)) begin
            // bad target: nothing
        end else begin
            r.cap = class_cap[class_of_handle(tgt)];
            case (act)
                ACT_FREE: begin
                    last = pool_link[tgt];
                    if (last != 0) begin
                        pos = pool_link[last];
                        n = 0;
                        while (pos != last && pos != 0 && n < NB) begin
                            nxt = pool_link[pos];
                            push_block(pos);
                            pos = nxt;
                            n++;
                        end
                        push_block(last);
                    end
                    push_block(tgt);
                end
                ACT_LINK: begin
                    if (handle_ok(sec)) begin
                        ml = pool_link[tgt];
                        sl = pool_link[sec];
                        if (ml == 0) begin
                            if (sl == 0) begin
                                pool_link[tgt] = HW'(sec);
                                pool_link[sec] = HW'(sec);
                            end else begin
                                pool_link[tgt] = HW'(sl);
                                pool_link[sec] = pool_link[sl];
                                pool_link[sl] = HW'(sec);
                            end
                        end else begin
                            mf = pool_link[ml];
                            if (sl == 0) begin
                                pool_link[tgt] = HW'(sec);
                                pool_link[sec] = HW'(mf);
                                pool_link[ml] = HW'(sec);
                            end else begin
                                pool_link[tgt] = HW'(sl);
                                pool_link[sec] = pool_link[sl];
                                pool_link[sl] = HW'(mf);
                                pool_link[ml] = HW'(sec);
                            end
                        end
                    end
                end
                ACT_ITER: begin
                    last = pool_link[tgt];
                    if (last == sec) r.handle = '0;
                    else if (sec == 0) r.handle = pool_link[last];
                    else if (handle_ok(sec)) r.handle = pool_link[sec];
                end
                default: begin
                    if (size > r.cap) r.status = ST_LEN;
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        pool_result_t want;
        pool_result_t got;
        if (!i_rst_n) begin
            reset_pool();
            pending_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            // configuration write transaction
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_CAP0: class_cap[0] = pwdata[15:0];
                    REG_CAP1: class_cap[1] = pwdata[15:0];
                    REG_CAP2: class_cap[2] = pwdata[15:0];
                    REG_CAP3: class_cap[3] = pwdata[15:0];
                    REG_RO:   read_only_mode = pwdata[0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = '{i_result_handle, i_status, i_capacity};
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: handle %0d status %0d cap %0d",
                                 got.handle, got.status, got.cap);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: handle %0d/%0d status %0d/%0d cap %0d/%0d (exp/act)",
                                     want.handle, got.handle, want.status, got.status,
                                     want.cap, got.cap);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // request transaction
            if (i_valid && !i_in_stall)
                pending_results.push_back(apply_action(i_action, i_request_size,
                                                       i_target_handle, i_second_handle));
            o_pending <= pending_results.size();
        end
    end
endmodule

### tb/tb_size_class_block_pool_manager.sv
// tb_size_class_block_pool_manager: stimulus, configuration phases and verdict
// depends on scbpm_pkg, size_class_block_pool_manager, scbpm_pool_checker
`timescale 1ns / 1ps
module tb_size_class_block_pool_manager;
    import scbpm_pkg::*;

    localparam int STALL_LIMIT = 6000;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          psel, penable, pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          i_valid, o_stall;
    logic [2:0]    i_action;
    logic [15:0]   i_request_size;
    logic [HW-1:0] i_target_handle, i_second_handle;
    logic          o_valid, i_stall;
    logic [HW-1:0] o_result_handle;
    logic [1:0]    o_status;
    logic [CW-1:0] o_capacity;
    int            fail_count, pending_count;
    int            quiet_cycles, stall_left;
    bit            gaps_on;

    always #10 i_clk = ~i_clk;

    size_class_block_pool_manager dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_action(i_action),
        .i_request_size(i_request_size), .i_target_handle(i_target_handle),
        .i_second_handle(i_second_handle), .o_valid(o_valid), .i_stall(i_stall),
        .o_result_handle(o_result_handle), .o_status(o_status), .o_capacity(o_capacity)
    );

    scbpm_pool_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_action(i_action),
        .i_request_size(i_request_size), .i_target_handle(i_target_handle),
        .i_second_handle(i_second_handle),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_result_handle(o_result_handle),
        .i_status(o_status), .i_capacity(o_capacity),
        .o_fail_count(fail_count), .o_pending(pending_count)
    );

    // receiver stall bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 6) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_caps(int c0, int c1, int c2, int c3);
        cfg_write(REG_CAP0, c0);
        cfg_write(REG_CAP1, c1);
        cfg_write(REG_CAP2, c2);
        cfg_write(REG_CAP3, c3);
    endtask

    // one request transaction, then maybe a sender gap
    task automatic send(logic [2:0] act, int size, int tgt, int sec);
        i_valid <= 1'b1;
        i_action <= act;
        i_request_size <= size[15:0];
        i_target_handle <= tgt[HW-1:0];
        i_second_handle <= sec[HW-1:0];
        do @(posedge i_clk); while (o_stall);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // drain all outstanding results before touching configuration
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic int pick_handle();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return $urandom_range(257, 511);
            2: return 256;
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 300);
            2: return $urandom_range(0, 5000);
            default: return 1 << $urandom_range(0, 15);
        endcase
    endfunction

    // random item; alloc_weight out of 10 are allocations
    task automatic send_random(int alloc_weight);
        int roll;
        logic [2:0] act;
        roll = $urandom_range(0, 9);
        if (roll < alloc_weight) act = ACT_ALLOC;
        else if ($urandom_range(0, 29) == 0) act = 3'($urandom_range(5, 7));
        else act = 3'($urandom_range(ACT_FREE, ACT_CHECK));
        send(act, pick_size(), pick_handle(),
             ($urandom_range(0, 3) == 0) ? 0 : pick_handle());
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_action <= ACT_ALLOC;
        i_request_size <= '0;
        i_target_handle <= '0;
        i_second_handle <= '0;
        gaps_on = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: class selection, fallback, chains, cursors, bad handles
        send(ACT_ALLOC, 0, 0, 0);
        send(ACT_ALLOC, 64, 0, 0);
        send(ACT_ALLOC, 65, 0, 0);
        send(ACT_ALLOC, 65535, 0, 0);
        send(ACT_LINK, 0, 1, 2);
        send(ACT_LINK, 0, 1, 65);
        send(ACT_LINK, 0, 193, 1);
        send(ACT_ITER, 0, 193, 0);
        send(ACT_ITER, 0, 193, 2);
        send(ACT_ITER, 0, 193, 65);
        send(ACT_ITER, 0, 193, 300);
        send(ACT_ITER, 0, 5, 0);
        send(ACT_CHECK, 64, 1, 0);
        send(ACT_CHECK, 65, 1, 0);
        send(ACT_CHECK, 65535, 511, 0);
        send(ACT_LINK, 0, 1, 0);
        send(ACT_LINK, 0, 1, 400);
        send(ACT_FREE, 0, 193, 0);
        send(ACT_FREE, 0, 0, 0);
        send(3'd5, 65535, 511, 511);
        send(3'd6, 0, 1, 1);
        send(3'd7, 0, 0, 0);
        send(ACT_ALLOC, 4097, 0, 0);
        send(ACT_FREE, 0, 2, 0);
        settle();

        // refused actions while read only, at extreme capacities
        set_caps(0, 65535, 0, 65535);
        cfg_write(REG_RO, 1);
        gaps_on = 1'b1;
        repeat (30) send_random(3);
        settle();
        cfg_write(REG_RO, 0);

        // drain the pool, mostly allocations
        set_caps(0, 0, 0, 0);
        repeat (140) send_random(8);
        settle();
        set_caps(65535, 65535, 65535, 65535);
        repeat (140) send_random(6);
        settle();

        // mixed traffic, last stretch without gaps
        set_caps(100, 1000, 10000, 40000);
        repeat (140) send_random(4);
        settle();
        set_caps(64, 256, 1024, 4096);
        gaps_on = 1'b0;
        repeat (80) send_random(4);
        settle();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
